[sv/crcgc_pkg.sv]
package crcgc_pkg;

    // Widest generator supported, and widths that follow from it
    localparam int MAX_DEGREE = 32;
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_DEG_W  = 6;
    localparam int POLY_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GEN_DEGREE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_POLY   = 1'd1;

    localparam logic [CFG_DEG_W-1:0] GEN_DEGREE_RST = 6'd3;
    localparam logic [POLY_W-1:0]    GEN_POLY_RST   = 32'd5;

    // Function codes
    localparam logic FUNC_GENERATE = 1'b0;
    localparam logic FUNC_CHECK    = 1'b1;

    // Job queue between front and back
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // One finished message: its mode, degree and final remainder
    typedef struct packed {
        logic                  func;
        logic [DEG_W-1:0]      deg;
        logic [MAX_DEGREE-1:0] rem;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Clamp the programmed degree to 1..MAX_DEGREE
    function automatic logic [DEG_W-1:0] eff_degree(input logic [CFG_DEG_W-1:0] cfg);
        logic [DEG_W-1:0] n;
        if (cfg == '0) begin
            n = DEG_W'(1);
        end else if (int'(cfg) > MAX_DEGREE) begin
            n = DEG_W'(MAX_DEGREE);
        end else begin
            n = DEG_W'(cfg);
        end
        return n;
    endfunction

    // Ones in the low n bits
    function automatic logic [MAX_DEGREE-1:0] low_mask(input logic [DEG_W-1:0] n);
        logic [MAX_DEGREE-1:0] m;
        for (int k = 0; k < MAX_DEGREE; k++) begin
            m[k] = (k < int'(n));
        end
        return m;
    endfunction

endpackage

[sv/crc_generate_and_check_core.sv]
// Channel   Direction  Transfer when              Payload
// input     in         push & !full               i_func, i_data_bit, i_last_bit
// result    out        pop & !empty               o_crc_bit, o_error_flag, o_end_of_run
// config    in         i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// One input bit per cycle: the remainder update is a single shift and XOR.
// A last bit queues a job (two deep); the back part delivers n result bits in
// generate mode or one in check mode, one per cycle while pop is held.
// Input stalls only when the job queue is full; results stall on pop alone.
// Reset is synchronous, active low; configuration is taken every cycle.
module crc_generate_and_check_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input bits
    input  logic                              push,
    output logic                              full,
    input  logic                              i_func,
    input  logic                              i_data_bit,
    input  logic                              i_last_bit,
    // results
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_crc_bit,
    output logic                              o_error_flag,
    output logic                              o_end_of_run,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [crcgc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [crcgc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    crcgc_pkg::t_job            front_job;
    crcgc_pkg::t_job            head_job;
    crcgc_pkg::t_queue_status   q_status;
    logic                       job_push;
    logic                       job_pop;
    logic                       accept;

    assign o_cfg_ready = 1'b1;
    assign full        = q_status.full;
    assign accept      = push & ~q_status.full;

    crcgc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_data_bit  (i_data_bit),
        .i_last_bit  (i_last_bit),
        .o_job_push  (job_push),
        .o_job       (front_job)
    );

    crcgc_job_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (job_push),
        .i_job    (front_job),
        .i_pop    (job_pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    crcgc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_job_empty  (q_status.empty),
        .o_job_pop    (job_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_crc_bit    (o_crc_bit),
        .o_error_flag (o_error_flag),
        .o_end_of_run (o_end_of_run)
    );

endmodule

[sv/crcgc_front.sv]
module crcgc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write
    input  logic                              i_cfg_valid,
    input  logic [crcgc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [crcgc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // accepted input bit
    input  logic                              i_accept,
    input  logic                              i_func,
    input  logic                              i_data_bit,
    input  logic                              i_last_bit,
    // finished message to the job queue
    output logic                              o_job_push,
    output crcgc_pkg::t_job                   o_job
);

    logic [crcgc_pkg::CFG_DEG_W-1:0]  r_gen_degree;
    logic [crcgc_pkg::POLY_W-1:0]     r_gen_poly;
    logic [crcgc_pkg::MAX_DEGREE-1:0] r_rem;
    logic [crcgc_pkg::MAX_DEGREE-1:0] n_rem;
    logic [crcgc_pkg::MAX_DEGREE-1:0] mask;
    logic [crcgc_pkg::MAX_DEGREE-1:0] poly;
    logic [crcgc_pkg::MAX_DEGREE-1:0] shifted;
    logic [crcgc_pkg::DEG_W-1:0]      deg;
    logic                             top;
    logic                             feedback;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_degree <= crcgc_pkg::GEN_DEGREE_RST;
            r_gen_poly   <= crcgc_pkg::GEN_POLY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crcgc_pkg::CFG_GEN_DEGREE:
                    r_gen_degree <= i_cfg_data[crcgc_pkg::CFG_DEG_W-1:0];
                crcgc_pkg::CFG_GEN_POLY:
                    r_gen_poly <= i_cfg_data[crcgc_pkg::POLY_W-1:0];
                default: ;
            endcase
        end
    end

    // One division step: shift, then subtract the generator on feedback
    always_comb begin
        deg  = crcgc_pkg::eff_degree(r_gen_degree);
        mask = crcgc_pkg::low_mask(deg);
        poly = crcgc_pkg::MAX_DEGREE'(r_gen_poly) & mask;
        top  = r_rem[crcgc_pkg::IDX_W'(deg - crcgc_pkg::DEG_W'(1))];
        if (i_func == crcgc_pkg::FUNC_GENERATE) begin
            shifted  = (r_rem << 1) & mask;
            feedback = top ^ i_data_bit;
        end else begin
            shifted  = ({r_rem[crcgc_pkg::MAX_DEGREE-2:0], i_data_bit}) & mask;
            feedback = top;
        end
        n_rem = feedback ? (shifted ^ poly) : shifted;
    end

    // Advance the remainder; clear it after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_accept) begin
            r_rem <= i_last_bit ? '0 : n_rem;
        end
    end

    // Hand the finished message to the back part
    assign o_job_push = i_accept & i_last_bit;
    assign o_job.func = i_func;
    assign o_job.deg  = deg;
    assign o_job.rem  = n_rem;

endmodule

[sv/crcgc_job_queue.sv]
module crcgc_job_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  crcgc_pkg::t_job           i_job,
    input  logic                      i_pop,
    output crcgc_pkg::t_job           o_job,
    output crcgc_pkg::t_queue_status  o_status
);

    crcgc_pkg::t_job                      r_mem [crcgc_pkg::JOB_DEPTH];
    logic [crcgc_pkg::JOB_PTR_W-1:0]      r_wr_ptr;
    logic [crcgc_pkg::JOB_PTR_W-1:0]      r_rd_ptr;
    logic [crcgc_pkg::JOB_CNT_W-1:0]      r_count;
    logic                                 do_push;
    logic                                 do_pop;

    assign o_status.full  = (r_count == crcgc_pkg::JOB_CNT_W'(crcgc_pkg::JOB_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push & ~o_status.full;
    assign do_pop  = i_pop & ~o_status.empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == crcgc_pkg::JOB_DEPTH - 1) ?
                            '0 : r_wr_ptr + crcgc_pkg::JOB_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == crcgc_pkg::JOB_DEPTH - 1) ?
                            '0 : r_rd_ptr + crcgc_pkg::JOB_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + crcgc_pkg::JOB_CNT_W'(1);
                2'b01:   r_count <= r_count - crcgc_pkg::JOB_CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

[sv/crcgc_back.sv]
module crcgc_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  crcgc_pkg::t_job           i_job,
    input  logic                      i_job_empty,
    output logic                      o_job_pop,
    // result side
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic                      o_crc_bit,
    output logic                      o_error_flag,
    output logic                      o_end_of_run
);

    logic                             r_busy;
    logic [crcgc_pkg::MAX_DEGREE-1:0] r_sh;
    logic [crcgc_pkg::DEG_W-1:0]      r_cnt;
    logic                             r_err;
    logic                             r_eor;
    logic                             n_busy;
    logic [crcgc_pkg::MAX_DEGREE-1:0] n_sh;
    logic [crcgc_pkg::DEG_W-1:0]      n_cnt;
    logic                             n_err;
    logic                             n_eor;
    logic                             taken;
    logic                             free;

    assign taken = i_pop & r_busy;
    assign free  = ~r_busy | (taken & r_eor);
    assign o_job_pop = free & ~i_job_empty;

    // Next result: load a new job, shift the current one, go idle, or hold
    always_comb begin
        n_busy = r_busy;
        n_sh   = r_sh;
        n_cnt  = r_cnt;
        n_err  = r_err;
        n_eor  = r_eor;
        if (o_job_pop) begin
            n_busy = 1'b1;
            if (i_job.func == crcgc_pkg::FUNC_GENERATE) begin
                // left-align the remainder so its MSB sits on top
                n_sh  = i_job.rem << (crcgc_pkg::DEG_W'(crcgc_pkg::MAX_DEGREE) - i_job.deg);
                n_cnt = i_job.deg;
                n_err = 1'b0;
                n_eor = (i_job.deg == crcgc_pkg::DEG_W'(1));
            end else begin
                n_sh  = '0;
                n_cnt = crcgc_pkg::DEG_W'(1);
                n_err = |i_job.rem;
                n_eor = 1'b1;
            end
        end else if (free) begin
            n_busy = 1'b0;
        end else if (taken) begin
            n_sh  = r_sh << 1;
            n_cnt = r_cnt - crcgc_pkg::DEG_W'(1);
            n_eor = (r_cnt == crcgc_pkg::DEG_W'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_cnt <= n_cnt;
        r_err <= n_err;
        r_eor <= n_eor;
    end

    assign o_empty      = ~r_busy;
    assign o_crc_bit    = r_sh[crcgc_pkg::MAX_DEGREE-1];
    assign o_error_flag = r_err;
    assign o_end_of_run = r_eor;

endmodule

[sv/crcgc_checker.sv]
module crcgc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic full,
    input  logic empty,
    input  logic pop,
    input  logic o_crc_bit,
    input  logic o_error_flag,
    input  logic o_end_of_run
);

    // Reset leaves both queues open and no result waiting
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result or full shown right after reset");

    // A result with the error flag set carries no CRC bit
    a_err_no_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_flag) |-> !o_crc_bit)
        else $error("error flag and crc bit both set");

    // An error flag only comes on the single, final result of a check
    a_err_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_flag) |-> o_end_of_run)
        else $error("error flag on a non-final result");

    // Hold a waiting result until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_crc_bit) && $stable(o_error_flag)
                              && $stable(o_end_of_run)))
        else $error("result changed while stalled");

endmodule

bind crc_generate_and_check_core crcgc_checker u_crcgc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_crc_bit    (o_crc_bit),
    .o_error_flag (o_error_flag),
    .o_end_of_run (o_end_of_run)
);

[bench/tb_top.sv]
module tb_top;

    localparam int CLK_PERIOD     = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES = 500000;

    // One result transfer as the block presents it
    typedef struct packed {
        logic crc_bit;
        logic error_flag;
        logic end_of_run;
    } t_crc_result;

    // Directed table: a message bit, or a new generator between messages
    typedef enum logic {ROW_BIT, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic             func;
        logic             data_bit;
        logic             last_bit;
        logic             typed;
        logic             error_flag;
        logic [31:0]      deg_word;
        logic [31:0]      poly_word;
    } t_stim_row;

    typedef enum logic [1:0] {MSG_GENERATE, MSG_CODEWORD, MSG_CORRUPT, MSG_NOISE} t_msg_kind;

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             push           = 1'b0;
    logic                             full;
    logic                             i_func         = 1'b0;
    logic                             i_data_bit     = 1'b0;
    logic                             i_last_bit     = 1'b0;
    logic                             empty;
    logic                             pop            = 1'b0;
    logic                             o_crc_bit;
    logic                             o_error_flag;
    logic                             o_end_of_run;
    logic                             i_cfg_valid    = 1'b0;
    logic                             o_cfg_ready;
    logic [crcgc_pkg::CFG_IDX_W-1:0]  i_cfg_index    = crcgc_pkg::CFG_GEN_DEGREE;
    logic [crcgc_pkg::CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Typed expectation travels with the bit it belongs to
    logic                             row_typed      = 1'b0;
    logic                             row_error_flag = 1'b0;

    // Predictor state and its copy of the generator registers
    logic [crcgc_pkg::CFG_DEG_W-1:0]  cfg_degree     = crcgc_pkg::GEN_DEGREE_RST;
    logic [crcgc_pkg::POLY_W-1:0]     cfg_poly       = crcgc_pkg::GEN_POLY_RST;
    logic [crcgc_pkg::MAX_DEGREE-1:0] crc_rem        = '0;
    t_crc_result                      pending_results[$];

    logic                             gaps_on        = 1'b1;
    logic                             hold_results   = 1'b0;
    int                               err_count      = 0;
    int                               bits_sent      = 0;
    int                               results_seen   = 0;
    int                               gen_msgs       = 0;
    int                               chk_msgs       = 0;
    int                               settings_used  = 0;
    int                               full_cycles    = 0;

    crc_generate_and_check_core dut (.*);

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    // Clamp the programmed degree into 1..MAX_DEGREE
    function automatic int effective_degree(input logic [crcgc_pkg::CFG_DEG_W-1:0] deg);
        return (deg == '0) ? 1 : ((int'(deg) > crcgc_pkg::MAX_DEGREE) ?
                                  crcgc_pkg::MAX_DEGREE : int'(deg));
    endfunction

    // Advance the partial remainder by one bit in the given mode
    function automatic logic [crcgc_pkg::MAX_DEGREE-1:0] next_remainder(
        input logic [crcgc_pkg::MAX_DEGREE-1:0] rem,
        input logic                             func,
        input logic                             data_bit,
        input int                               n,
        input logic [crcgc_pkg::POLY_W-1:0]     poly_word
    );
        logic [crcgc_pkg::MAX_DEGREE-1:0] mask;
        logic [crcgc_pkg::MAX_DEGREE-1:0] taps;
        logic [crcgc_pkg::MAX_DEGREE-1:0] r;
        logic                             top;
        mask = {crcgc_pkg::MAX_DEGREE{1'b1}} >> (crcgc_pkg::MAX_DEGREE - n);
        taps = crcgc_pkg::MAX_DEGREE'(poly_word) & mask;
        top  = rem[n-1];
        if (func == crcgc_pkg::FUNC_GENERATE) begin
            r = (rem << 1) & mask;
            if (top ^ data_bit) r = r ^ taps;
        end else begin
            r = {rem[crcgc_pkg::MAX_DEGREE-2:0], data_bit} & mask;
            if (top) r = r ^ taps;
        end
        return r;
    endfunction

    // Update the remainder and queue the results a last bit releases
    task automatic predict_crc_bit(input logic func, data_bit, last_bit, typed, typed_flag);
        int          n;
        t_crc_result r;
        n = effective_degree(cfg_degree);
        crc_rem = next_remainder(crc_rem, func, data_bit, n, cfg_poly);
        if (last_bit) begin
            if (func == crcgc_pkg::FUNC_GENERATE) begin
                for (int k = n - 1; k >= 0; k--) begin
                    r.crc_bit    = crc_rem[k];
                    r.error_flag = 1'b0;
                    r.end_of_run = (k == 0);
                    pending_results.push_back(r);
                end
                gen_msgs++;
            end else begin
                r.crc_bit    = 1'b0;
                r.error_flag = typed ? typed_flag : (crc_rem != '0);
                r.end_of_run = 1'b1;
                pending_results.push_back(r);
                chk_msgs++;
            end
            crc_rem = '0;
        end
    endtask

    // Check result transfers, then predict from input and config transfers
    always @(posedge i_clk) begin : monitor
        t_crc_result want;
        if (!i_rst_n) begin
            cfg_degree = crcgc_pkg::GEN_DEGREE_RST;
            cfg_poly   = crcgc_pkg::GEN_POLY_RST;
            crc_rem    = '0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.crc_bit !== o_crc_bit) begin
                        $error("crc_bit: expected %0b, got %0b", want.crc_bit, o_crc_bit);
                        err_count++;
                    end
                    if (want.error_flag !== o_error_flag) begin
                        $error("error_flag: expected %0b, got %0b", want.error_flag,
                               o_error_flag);
                        err_count++;
                    end
                    if (want.end_of_run !== o_end_of_run) begin
                        $error("end_of_run: expected %0b, got %0b", want.end_of_run,
                               o_end_of_run);
                        err_count++;
                    end
                end
            end
            if (push && !full) begin
                predict_crc_bit(i_func, i_data_bit, i_last_bit, row_typed, row_error_flag);
            end else if (push) begin
                full_cycles++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == crcgc_pkg::CFG_GEN_DEGREE) begin
                    cfg_degree = i_cfg_data[crcgc_pkg::CFG_DEG_W-1:0];
                end else begin
                    cfg_poly = i_cfg_data[crcgc_pkg::POLY_W-1:0];
                end
            end
        end
    end

    // Result side: random stall bursts, one long hold on request
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one bit and hold it until the block takes it
    task automatic offer_bit(input logic func, data_bit, last_bit, typed, typed_flag);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_func         <= func;
        i_data_bit     <= data_bit;
        i_last_bit     <= last_bit;
        row_typed      <= typed;
        row_error_flag <= typed_flag;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bits_sent++;
    endtask

    // Drop push, wait out every expected result, then let the block settle
    task automatic wait_results_drained();
        int waited;
        push <= 1'b0;
        waited = 0;
        // let the monitor queue what the last transfer releases
        @(posedge i_clk);
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write degree then polynomial, valid held across both transfers
    task automatic program_generator(input logic [31:0] deg_word, poly_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= crcgc_pkg::CFG_GEN_DEGREE;
        i_cfg_data  <= deg_word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= crcgc_pkg::CFG_GEN_POLY;
        i_cfg_data  <= poly_word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random generator, leaning on the extremes and on small degrees
    task automatic pick_generator(output logic [31:0] deg_word, poly_word);
        case ($urandom_range(0, 8))
            0: deg_word = 32'd1;
            1: deg_word = 32'd32;
            2: deg_word = 32'd0;
            3: deg_word = {26'($urandom()), 6'd63};
            4: deg_word = $urandom_range(33, 62);
            default: deg_word = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 3))
            0: poly_word = '0;
            1: poly_word = '1;
            default: poly_word = $urandom();
        endcase
    endtask

    // Send one message: plain data, a valid or broken codeword, or mixed noise
    task automatic send_message(input t_msg_kind kind, input int len);
        logic                             payload[$];
        logic [crcgc_pkg::MAX_DEGREE-1:0] rem;
        logic                             func;
        logic                             last_bit;
        int                               n;
        int                               flip;
        for (int k = 0; k < len; k++) payload.push_back(1'($urandom_range(0, 1)));
        n = effective_degree(cfg_degree);
        case (kind)
            MSG_GENERATE: begin
                foreach (payload[k])
                    offer_bit(crcgc_pkg::FUNC_GENERATE, payload[k],
                              k == payload.size() - 1, 1'b0, 1'b0);
            end
            MSG_NOISE: begin
                foreach (payload[k]) begin
                    func     = $urandom_range(0, 1) ? crcgc_pkg::FUNC_CHECK :
                                                      crcgc_pkg::FUNC_GENERATE;
                    last_bit = (k == payload.size() - 1) || ($urandom_range(0, 3) == 0);
                    offer_bit(func, payload[k], last_bit, 1'b0, 1'b0);
                end
            end
            default: begin
                // append the CRC so the codeword divides evenly, then maybe break it
                rem = '0;
                foreach (payload[k])
                    rem = next_remainder(rem, crcgc_pkg::FUNC_GENERATE, payload[k], n,
                                         cfg_poly);
                for (int k = n - 1; k >= 0; k--) payload.push_back(rem[k]);
                if (kind == MSG_CORRUPT) begin
                    flip = $urandom_range(0, payload.size() - 1);
                    payload[flip] = ~payload[flip];
                end
                foreach (payload[k])
                    offer_bit(crcgc_pkg::FUNC_CHECK, payload[k],
                              k == payload.size() - 1, 1'b0, 1'b0);
            end
        endcase
    endtask

    // Send messages until the phase has moved enough bits
    task automatic run_phase(input int bit_goal);
        int start;
        int pick;
        start = bits_sent;
        while (bits_sent - start < bit_goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) send_message(MSG_GENERATE, $urandom_range(1, 10));
            else if (pick < 6) send_message(MSG_CODEWORD, $urandom_range(1, 10));
            else if (pick < 8) send_message(MSG_CORRUPT, $urandom_range(1, 10));
            else send_message(MSG_NOISE, $urandom_range(1, 10));
        end
    endtask

    function automatic t_stim_row bit_row(input logic func, data_bit, last_bit);
        t_stim_row r;
        r = '0;
        r.kind     = ROW_BIT;
        r.func     = func;
        r.data_bit = data_bit;
        r.last_bit = last_bit;
        return r;
    endfunction

    function automatic t_stim_row check_row(input logic data_bit, error_flag);
        t_stim_row r;
        r = bit_row(crcgc_pkg::FUNC_CHECK, data_bit, 1'b1);
        r.typed      = 1'b1;
        r.error_flag = error_flag;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [31:0] deg_word, poly_word);
        t_stim_row r;
        r = '0;
        r.kind      = ROW_CONFIG;
        r.deg_word  = deg_word;
        r.poly_word = poly_word;
        return r;
    endfunction

    initial begin
        t_stim_row   directed_rows[$];
        logic [31:0] deg_word;
        logic [31:0] poly_word;

        // Reset generator is x^3 + x^2 + 1
        directed_rows = '{
            check_row(1'b0, 1'b0),                                 // all-zero short codeword
            check_row(1'b1, 1'b1),                                 // short codeword with a one
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b1),
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b0),         // message 1011
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b0, 1'b0),
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b0),
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b1),
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b1, 1'b0),            // codeword 1011100
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b0, 1'b0),
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b1, 1'b0),
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b1, 1'b0),
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b1, 1'b0),
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b0, 1'b0),
            check_row(1'b0, 1'b0),
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b0),         // mode switched, ends in check
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b1, 1'b1),
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b1, 1'b0),            // ends in generate
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b0, 1'b1),
            cfg_row(32'd1, 32'd1),                                 // parity
            bit_row(crcgc_pkg::FUNC_CHECK, 1'b1, 1'b0),
            check_row(1'b1, 1'b0),
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b1),
            cfg_row(32'd32, 32'hFFFF_FFFF),                        // widest generator
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b1),
            check_row(1'b1, 1'b1),
            cfg_row(32'd0, 32'hFFFF_FFFE),                         // degree zero, high taps ignored
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b1),
            cfg_row(32'hFFFF_FFFF, 32'h8000_0001),                 // degree past the top
            check_row(1'b0, 1'b0),
            bit_row(crcgc_pkg::FUNC_GENERATE, 1'b1, 1'b1)
        };

        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CONFIG) begin
                wait_results_drained();
                program_generator(directed_rows[r].deg_word, directed_rows[r].poly_word);
            end else begin
                offer_bit(directed_rows[r].func, directed_rows[r].data_bit,
                          directed_rows[r].last_bit, directed_rows[r].typed,
                          directed_rows[r].error_flag);
            end
        end

        // Random phases, each under its own generator
        for (int p = 0; p < 4; p++) begin
            wait_results_drained();
            pick_generator(deg_word, poly_word);
            program_generator(deg_word, poly_word);
            run_phase(20);
        end

        // Hold results off while short messages keep coming, so the job queue fills
        wait_results_drained();
        program_generator(32'd4, $urandom());
        gaps_on      = 1'b0;
        hold_results = 1'b1;
        for (int m = 0; m < 12; m++) send_message(MSG_GENERATE, $urandom_range(1, 2));

        // Finish with back-to-back traffic on both sides
        wait_results_drained();
        pick_generator(deg_word, poly_word);
        program_generator(deg_word, poly_word);
        run_phase(20);
        wait_results_drained();

        $display("Sent %0d bits under %0d generator settings:", bits_sent, settings_used);
        $display("%0d CRCs generated, %0d codewords checked, %0d result transfers checked.",
                 gen_msgs, chk_msgs, results_seen);
        $display("Input held off by a full queue on %0d cycles.", full_cycles);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
